FILE: design/itw_pkg.sv
// Shared constants and types for the interpolated table waveshaper.
package itw_pkg;

  // Payload field widths
  localparam int SAMPLE_W     = 24;
  localparam int ENTRY_W      = 24;
  localparam int ENTRY_ADDR_W = 10;

  // Curve geometry and sample format
  localparam int TABLE_POINTS = 512;
  localparam int LOG2_POINTS  = $clog2(TABLE_POINTS);
  localparam int TABLE_DEPTH  = TABLE_POINTS + 1;
  localparam int ADDR_W       = LOG2_POINTS + 1;
  localparam int FRAC_BITS    = 20;

  // Datapath widths
  localparam int IDX_W  = ((SAMPLE_W > FRAC_BITS) ? SAMPLE_W : FRAC_BITS) + 2;
  localparam int POS_W  = IDX_W + LOG2_POINTS;
  localparam int DIFF_W = ENTRY_W + 1;
  localparam int PROD_W = FRAC_BITS + 1 + DIFF_W;

  // Item function codes
  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_WRITE  = 1'b1;

  typedef logic signed [ENTRY_W-1:0] entry_t;
  typedef logic [ADDR_W-1:0]         addr_t;
  typedef logic [FRAC_BITS-1:0]      frac_t;

endpackage

FILE: design/itw_ram.sv
// Generic single-write, single-read RAM with registered read data.
module itw_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 513
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: design/interpolated_table_waveshaper_core.sv
// Top level of the interpolated table waveshaper: curve store and shaping pipeline.
//
// The block maps each signed Q4.20 sample through a curve of TABLE_POINTS+1
// stored points. A transfer with func = FUNC_WRITE loads one curve entry
// (addresses above TABLE_POINTS are dropped) and returns nothing; a transfer
// with func = FUNC_SAMPLE returns one shaped sample. The sample is offset by
// one half and scaled by TABLE_POINTS to give a table position; positions
// below zero return entry 0, positions at or past the end return the last
// entry, and anything else interpolates linearly between the two neighbor
// entries, rounding to nearest with ties toward plus infinity. Every entry a
// sample touches must have been written first. One item is taken per clock
// while the pipeline is not held. A sample passes four register stages
// (curve read, difference, multiply, round and add into the result
// register), and rsp_valid rises as it enters the result register. The
// curve is held twice, one copy feeding the lower neighbor and one the
// upper, so both points are read in the same cycle. When the result
// register is full and the consumer stalls, the whole pipeline holds and
// req_stall is raised; nothing is dropped or repeated.
module interpolated_table_waveshaper_core
  import itw_pkg::*;
(
  input  logic                           clk,
  input  logic                           rst,
  // request channel
  input  logic                           req_valid,
  output logic                           req_stall,
  input  logic                           func,
  input  logic signed [SAMPLE_W-1:0]     sample_in,
  input  logic [ENTRY_ADDR_W-1:0]        entry_addr,
  input  logic signed [ENTRY_W-1:0]      entry_value,
  // response channel
  output logic                           rsp_valid,
  input  logic                           rsp_stall,
  output logic signed [SAMPLE_W-1:0]     sample_out
);

  localparam logic signed [IDX_W-1:0]  HALF_IDX  = IDX_W'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [PROD_W-1:0] HALF_PROD = PROD_W'(1) <<< (FRAC_BITS - 1);
  localparam addr_t                    LAST_ADDR = ADDR_W'(TABLE_POINTS);

  // Whole pipeline advances together when the result register can move.
  logic move;
  assign move      = !rsp_valid || !rsp_stall;
  assign req_stall = !move;

  logic take;
  assign take = req_valid && move;

  // ---------------- curve writes ----------------
  logic  wr_en;
  addr_t wr_addr;
  assign wr_en   = take && (func == FUNC_WRITE) &&
                   (32'(entry_addr) <= 32'(TABLE_POINTS));
  assign wr_addr = ADDR_W'(entry_addr);

  // ---------------- stage 0: position and read addresses ----------------
  logic signed [IDX_W-1:0] idx;
  logic [POS_W-1:0]        pos;
  logic                    neg, over, clamp;
  addr_t                   lo_addr, hi_addr;

  always_comb begin
    idx   = IDX_W'(sample_in) + HALF_IDX;
    pos   = {idx, {LOG2_POINTS{1'b0}}};
    neg   = idx[IDX_W-1];
    // integer part of the position reaches TABLE_POINTS or more
    over  = !neg && (|pos[POS_W-2:FRAC_BITS+LOG2_POINTS]);
    clamp = neg || over;
    if (neg) begin
      lo_addr = '0;
    end else if (over) begin
      lo_addr = LAST_ADDR;
    end else begin
      lo_addr = {1'b0, pos[FRAC_BITS+LOG2_POINTS-1:FRAC_BITS]};
    end
    hi_addr = clamp ? lo_addr : lo_addr + addr_t'(1);
  end

  logic [ENTRY_W-1:0] lo_rd, hi_rd;

  itw_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_ram_lo (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (entry_value),
    .rd_en   (move),
    .rd_addr (lo_addr),
    .rd_data (lo_rd)
  );

  itw_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_ram_hi (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (entry_value),
    .rd_en   (move),
    .rd_addr (hi_addr),
    .rd_data (hi_rd)
  );

  // ---------------- stage 1: entries read ----------------
  logic  v1, clamp1;
  frac_t frac1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (move) begin
      v1 <= req_valid && (func == FUNC_SAMPLE);
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      clamp1 <= clamp;
      frac1  <= pos[FRAC_BITS-1:0];
    end
  end

  // ---------------- stage 2: neighbor difference ----------------
  logic                     v2, clamp2;
  frac_t                    frac2;
  entry_t                   lo2;
  logic signed [DIFF_W-1:0] diff2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (move) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      clamp2 <= clamp1;
      frac2  <= frac1;
      lo2    <= signed'(lo_rd);
      diff2  <= DIFF_W'(signed'(hi_rd)) - DIFF_W'(signed'(lo_rd));
    end
  end

  // ---------------- stage 3: fraction times difference ----------------
  logic                     v3, clamp3;
  entry_t                   lo3;
  logic signed [PROD_W-1:0] prod3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (move) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      clamp3 <= clamp2;
      lo3    <= lo2;
      prod3  <= PROD_W'(signed'({1'b0, frac2})) * PROD_W'(diff2);
    end
  end

  // ---------------- stage 4: round, add, result register ----------------
  logic signed [PROD_W-1:0] rounded;
  entry_t                   shaped;

  always_comb begin
    rounded = (prod3 + HALF_PROD) >>> FRAC_BITS;
    // interpolated value always lies between the neighbors, so it fits
    shaped  = clamp3 ? lo3 : lo3 + ENTRY_W'(rounded);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (move) begin
      rsp_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      sample_out <= shaped;
    end
  end

endmodule

FILE: tb/interpolated_table_waveshaper_core_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the interpolated table waveshaper core.
module interpolated_table_waveshaper_core_test;
  import itw_pkg::*;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // one row of the directed stimulus table
  typedef struct {
    logic                    f;
    sample_t                 smp;
    logic [ENTRY_ADDR_W-1:0] addr;
    entry_t                  val;
    bit                      typed;   // want holds a hand-written result
    entry_t                  want;
  } stim_row_t;

  localparam int     WATCHDOG_LIMIT = 4000;
  localparam int     DRAIN_CYCLES   = 16;
  localparam int     PHASE_ITEMS    = 39;
  localparam int     N_ROWS         = 21;
  localparam int     ADDR_TOP       = (1 << ENTRY_ADDR_W) - 1;
  localparam entry_t ENTRY_MIN      = {1'b1, {(ENTRY_W-1){1'b0}}};
  localparam entry_t ENTRY_MAX      = {1'b0, {(ENTRY_W-1){1'b1}}};
  localparam longint HALF           = longint'(1) << (FRAC_BITS - 1);
  localparam longint ZERO_POS       = -HALF;  // sample value at table position zero
  localparam int     SEG_STEP       = 1 << (FRAC_BITS - LOG2_POINTS);

  logic                    clk         = 1'b0;
  logic                    rst         = 1'b1;
  logic                    req_valid   = 1'b0;
  logic                    req_stall;
  logic                    func        = FUNC_SAMPLE;
  sample_t                 sample_in   = '0;
  logic [ENTRY_ADDR_W-1:0] entry_addr  = '0;
  entry_t                  entry_value = '0;
  logic                    rsp_valid;
  logic                    rsp_stall   = 1'b0;
  sample_t                 sample_out;

  entry_t    curve_copy [TABLE_DEPTH];  // mirror of the curve store
  entry_t    shaped_due [$];            // shaped samples still owed by the block
  stim_row_t rows [N_ROWS];
  int        src_idle_pct   = 0;
  int        sink_stall_pct = 0;
  int        errors         = 0;
  int        quiet          = 0;

  interpolated_table_waveshaper_core dut (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .func        (func),
    .sample_in   (sample_in),
    .entry_addr  (entry_addr),
    .entry_value (entry_value),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .sample_out  (sample_out)
  );

  always #2 clk = ~clk;

  // Offset by one half, scale to a table position, clamp at both ends,
  // else interpolate with round to nearest, ties up.
  function automatic entry_t shape_sample(input sample_t x);
    longint pidx, pos, seg, frac, lo, hi, acc, res;
    pidx = longint'(x) + HALF;
    if (pidx < 0) return curve_copy[0];
    pos = pidx * TABLE_POINTS;
    seg = pos >>> FRAC_BITS;
    if (seg >= TABLE_POINTS) return curve_copy[TABLE_POINTS];
    frac = pos & ((longint'(1) << FRAC_BITS) - 1);
    lo   = curve_copy[seg];
    hi   = curve_copy[seg + 1];
    acc  = frac * (hi - lo) + HALF;
    res  = lo + (acc >>> FRAC_BITS);
    return res[ENTRY_W-1:0];
  endfunction

  // sample that lands sub units into segment seg
  function automatic sample_t seg_sample(input int seg, input int sub);
    longint p;
    p = ZERO_POS + longint'(seg) * SEG_STEP + sub;
    return p[SAMPLE_W-1:0];
  endfunction

  function automatic entry_t rand_entry();
    case ($urandom_range(0, 9))
      0:       return ENTRY_MIN;
      1:       return ENTRY_MAX;
      2:       return '0;
      default: return entry_t'($urandom);
    endcase
  endfunction

  // Offer one item, hold it until the transfer, then update the mirror
  // or queue the expected shaped sample.
  task automatic push_item(input logic f, input sample_t s, input logic [ENTRY_ADDR_W-1:0] a,
                           input entry_t v, input bit typed, input entry_t want);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid   <= 1'b1;
    func        <= f;
    sample_in   <= s;
    entry_addr  <= a;
    entry_value <= v;
    do @(posedge clk); while (!(req_valid && !req_stall));
    if (f == FUNC_WRITE) begin
      if (a <= TABLE_POINTS) curve_copy[a] = v;
    end else begin
      shaped_due.push_back(typed ? want : shape_sample(s));
    end
  endtask

  // sender goes quiet until every owed result has come back
  task automatic wait_for_results();
    req_valid <= 1'b0;
    do @(posedge clk); while (shaped_due.size() != 0);
  endtask

  // response side: random stall, compare each transfer with the oldest expectation
  always @(posedge clk) begin
    entry_t want;
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (shaped_due.size() == 0) begin
          if (errors < 10) $display("unexpected transfer: sample_out %0d", sample_out);
          errors++;
        end else begin
          want = shaped_due.pop_front();
          if (sample_out !== want) begin
            if (errors < 10)
              $display("sample_out mismatch: expected %0d, got %0d", want, sample_out);
            errors++;
          end
        end
      end
      rsp_stall <= ($urandom_range(0, 99) < sink_stall_pct);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("interpolated_table_waveshaper_core_test NOT OK");
      $finish;
    end
  end

  initial begin
    int                      r;
    logic                    f;
    sample_t                 s;
    logic [ENTRY_ADDR_W-1:0] a;
    entry_t                  v;

    // Directed rows. Clamp cases and position zero get hand-written results;
    // the rest go through the predictor.
    rows[0]  = '{FUNC_WRITE,  '0, 0, ENTRY_MIN, 1'b0, '0};
    rows[1]  = '{FUNC_WRITE,  '0, TABLE_POINTS, ENTRY_MAX, 1'b0, '0};
    rows[2]  = '{FUNC_SAMPLE, {1'b1, {(SAMPLE_W-1){1'b0}}}, 0, '0, 1'b1, ENTRY_MIN};
    rows[3]  = '{FUNC_SAMPLE, {1'b0, {(SAMPLE_W-1){1'b1}}}, 0, '0, 1'b1, ENTRY_MAX};
    rows[4]  = '{FUNC_SAMPLE, seg_sample(0, -1), 0, '0, 1'b1, ENTRY_MIN};          // just below zero
    rows[5]  = '{FUNC_SAMPLE, seg_sample(TABLE_POINTS, 0), 0, '0, 1'b1, ENTRY_MAX}; // exactly at end
    rows[6]  = '{FUNC_WRITE,  '0, 1, ENTRY_MAX, 1'b0, '0};
    rows[7]  = '{FUNC_SAMPLE, seg_sample(0, 0), 0, '0, 1'b1, ENTRY_MIN};           // position zero
    rows[8]  = '{FUNC_SAMPLE, seg_sample(0, SEG_STEP - 1), 0, '0, 1'b0, '0};       // full swing, top frac
    rows[9]  = '{FUNC_WRITE,  '0, 2, '0, 1'b0, '0};
    rows[10] = '{FUNC_WRITE,  '0, 3, 1, 1'b0, '0};
    rows[11] = '{FUNC_SAMPLE, seg_sample(2, SEG_STEP / 2), 0, '0, 1'b0, '0};       // rounding tie
    rows[12] = '{FUNC_WRITE,  '0, TABLE_POINTS + 1, 12345, 1'b0, '0};              // past the table
    rows[13] = '{FUNC_WRITE,  '0, ADDR_TOP, -1, 1'b0, '0};                         // past the table
    rows[14] = '{FUNC_SAMPLE, seg_sample(1, SEG_STEP / 2), 0, '0, 1'b0, '0};
    rows[15] = '{FUNC_SAMPLE, seg_sample(TABLE_POINTS, -1), 0, '0, 1'b0, '0};
    rows[16] = '{FUNC_SAMPLE, seg_sample(5, SEG_STEP / 4), 5, 777, 1'b0, '0};       // write fields ignored
    rows[17] = '{FUNC_SAMPLE, seg_sample(5, 100), 0, '0, 1'b0, '0};
    rows[18] = '{FUNC_WRITE,  {1'b0, {(SAMPLE_W-1){1'b1}}}, 4, ENTRY_MIN, 1'b0, '0};// sample field ignored
    rows[19] = '{FUNC_SAMPLE, seg_sample(4, SEG_STEP / 2), 0, '0, 1'b0, '0};
    rows[20] = '{FUNC_SAMPLE, '0, 0, '0, 1'b0, '0};

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int ph = 0; ph < 3; ph++) begin
      src_idle_pct   = (ph == 0) ? 22 : (ph == 1) ? 82 : 0;
      sink_stall_pct = (ph == 0) ? 82 : (ph == 1) ? 22 : 0;

      if (ph == 0) begin
        // every curve entry is loaded before any sample can read it
        for (int k = 0; k <= TABLE_POINTS; k++)
          push_item(FUNC_WRITE, sample_t'($urandom), ENTRY_ADDR_W'(k), rand_entry(),
                    1'b0, '0);
        for (int k = 0; k < N_ROWS; k++)
          push_item(rows[k].f, rows[k].smp, rows[k].addr, rows[k].val,
                    rows[k].typed, rows[k].want);
      end

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // unused fields carry noise
        s = sample_t'($urandom);
        a = ENTRY_ADDR_W'($urandom);
        v = entry_t'($urandom);
        f = ($urandom_range(0, 99) < 30) ? FUNC_WRITE : FUNC_SAMPLE;
        if (f == FUNC_WRITE) begin
          a = ($urandom_range(0, 9) == 0) ?
              ENTRY_ADDR_W'($urandom_range(TABLE_POINTS + 1, ADDR_TOP)) :
              ENTRY_ADDR_W'($urandom_range(0, TABLE_POINTS));
          v = rand_entry();
        end else begin
          r = $urandom_range(0, 99);
          if (r < 65)
            s = seg_sample($urandom_range(0, TABLE_POINTS - 1), $urandom_range(0, SEG_STEP - 1));
          else if (r < 80)
            s = sample_t'($urandom);
          else if (r < 90)  // around both clamp edges
            s = seg_sample(($urandom_range(0, 1) != 0) ? TABLE_POINTS : 0,
                           int'($urandom_range(0, 6)) - 3);
          else              // half-way points hit rounding ties
            s = seg_sample($urandom_range(0, TABLE_POINTS - 1), SEG_STEP / 2);
        end
        push_item(f, s, a, v, 1'b0, '0);
      end

      // hold the sender off once until the pipeline has fully emptied
      if (ph == 0) wait_for_results();
    end

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && shaped_due.size() == 0) begin
      $display("interpolated_table_waveshaper_core_test OK");
    end else begin
      $display("interpolated_table_waveshaper_core_test NOT OK");
    end
    $finish;
  end

endmodule
